@@ design/qphm_pkg.sv @@
package qphm_pkg;

  localparam int MAX_BUCKETS = 1024;
  localparam int MIN_BUCKETS = 8;
  localparam int MAX_PROBES  = 64;

  localparam int IDX_W  = $clog2(MAX_BUCKETS);
  localparam int MAX_LG = $clog2(MAX_BUCKETS);
  localparam int MIN_LG = $clog2(MIN_BUCKETS);
  localparam int LG_W   = $clog2(MAX_LG + 1);
  localparam int PCNT_W = $clog2(MAX_PROBES);
  localparam int CMP_W  = IDX_W + 4;
  localparam int ADDR_W = IDX_W + 1;

  localparam logic [1:0] M_INSERT = 2'd0;
  localparam logic [1:0] M_REMOVE = 2'd1;
  localparam logic [1:0] M_LOOKUP = 2'd2;

  localparam logic [1:0] E_OK    = 2'd0;
  localparam logic [1:0] E_PROBE = 2'd1;
  localparam logic [1:0] E_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_PRD, ST_PCHK, ST_RCLR, ST_RRD, ST_RCHK, ST_DONE
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] hash;
    logic [63:0] value;
  } slot_t;

  function automatic logic [IDX_W-1:0] lg_mask(input logic [LG_W-1:0] lg);
    logic [IDX_W:0] s;
    s = (IDX_W+1)'(1) << lg;
    return IDX_W'(s - (IDX_W+1)'(1));
  endfunction

  function automatic logic [IDX_W:0] lg_size(input logic [LG_W-1:0] lg);
    return (IDX_W+1)'(1) << lg;
  endfunction

endpackage

@@ design/quadratic_probe_hash_map.sv @@
// Open-addressed key/value table, one item at a time. An item probes its slots
// in turn: a registered memory read of the slot, then a compare and a step to
// the next slot. An insert that grows or a remove that shrinks the table then
// rehashes it: it clears every slot of the new size in the other bank, then
// reads each old slot and re-probes each valid entry into that bank. After
// reset, the slots of the minimum-size table are cleared before the first item
// is taken. in_stall is high whenever an item is in progress.
module quadratic_probe_hash_map
  import qphm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] key,
  input  logic [31:0] key_hash,
  input  logic [63:0] value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [63:0] value_out,
  output logic [1:0]  error
);

  state_t state, state_next;

  slot_t mem [2**ADDR_W];
  slot_t rdata;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  slot_t             wr_data;

  logic [1:0]        mode_r;
  logic [31:0]       key_r, hash_r;
  logic [63:0]       val_r;
  logic              rehash;
  logic [31:0]       p, pp;
  logic [IDX_W-1:0]  idx, pmask;
  logic              pbank;
  logic [PCNT_W-1:0] probe_n;

  logic              bank;
  logic [LG_W-1:0]   size_log2, nlg;
  logic [IDX_W:0]    fill_count, scan_i;
  logic [IDX_W-1:0]  cnt;
  logic              dst;

  logic              res_found;
  logic [63:0]       res_value;
  logic [1:0]        res_error;

  logic [31:0]       psum, p_new;
  logic              pr_empty, pr_match, pr_limit, pr_stop;
  logic [IDX_W:0]    fill_inc, fill_dec;
  logic              grow, shrink;
  logic              out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign psum     = pp + p;
  assign p_new    = {1'b0, psum[31:1]};
  assign pr_empty = !rdata.valid;
  assign pr_match = !rehash && rdata.valid && (rdata.key == key_r);
  assign pr_limit = !pr_empty && !pr_match && (probe_n == PCNT_W'(MAX_PROBES - 1));
  assign pr_stop  = pr_empty || pr_match || pr_limit;

  assign fill_inc = fill_count + (IDX_W+1)'(1);
  assign fill_dec = (fill_count != '0) ? fill_count - (IDX_W+1)'(1) : fill_count;
  assign grow   = (CMP_W'(fill_inc) + CMP_W'(2)) * CMP_W'(5)
                  > CMP_W'(lg_size(size_log2)) * CMP_W'(3);
  assign shrink = ((CMP_W'(fill_dec) + CMP_W'(2)) * CMP_W'(5)
                  < CMP_W'(lg_size(size_log2)))
                  && (lg_size(size_log2) > (IDX_W+1)'(MIN_BUCKETS))
                  && (size_log2 != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: if (cnt == lg_mask(nlg)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) state_next = (mode > M_LOOKUP) ? ST_DONE : ST_PRD;
      end
      ST_PRD:  state_next = ST_PCHK;
      ST_PCHK: begin
        if (!pr_stop) begin
          state_next = ST_PRD;
        end else if (rehash) begin
          state_next = pr_empty ? ST_RRD : ST_DONE;
        end else if (mode_r == M_INSERT && pr_empty && grow
                     && size_log2 != LG_W'(MAX_LG)) begin
          state_next = ST_RCLR;
        end else if (mode_r == M_REMOVE && pr_match && shrink) begin
          state_next = ST_RCLR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RCLR: if (cnt == lg_mask(nlg)) state_next = ST_RRD;
      ST_RRD:  state_next = (scan_i == lg_size(size_log2)) ? ST_DONE : ST_RCHK;
      ST_RCHK: state_next = rdata.valid ? ST_PRD : ST_RRD;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {pbank, idx};
    wr_data = '{valid: rehash || (mode_r != M_REMOVE), key: key_r, hash: hash_r,
                value: val_r};
    rd_addr = {pbank, idx};
    unique case (state)
      ST_INIT, ST_RCLR: begin
        wr_en   = 1'b1;
        wr_addr = {dst, cnt};
        wr_data.valid = 1'b0;
      end
      ST_PCHK: begin
        if (rehash) wr_en = pr_empty;
        else if (mode_r == M_INSERT) wr_en = pr_empty || pr_match;
        else if (mode_r == M_REMOVE) wr_en = pr_match;
      end
      ST_RRD: rd_addr = {bank, scan_i[IDX_W-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      bank       <= 1'b0;
      dst        <= 1'b0;
      size_log2  <= LG_W'(MIN_LG);
      nlg        <= LG_W'(MIN_LG);
      fill_count <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_INIT: cnt <= cnt + IDX_W'(1);
        ST_IDLE: begin
          mode_r    <= mode;
          key_r     <= key;
          hash_r    <= key_hash;
          val_r     <= value_in;
          rehash    <= 1'b0;
          p         <= 32'd2;
          idx       <= key_hash[IDX_W-1:0] & lg_mask(size_log2);
          pmask     <= lg_mask(size_log2);
          pbank     <= bank;
          probe_n   <= '0;
          res_found <= 1'b0;
          res_value <= '0;
          res_error <= E_OK;
        end
        ST_PRD: pp <= 32'(p * p);
        ST_PCHK: begin
          if (!pr_stop) begin
            p       <= p_new;
            idx     <= (idx + p_new[IDX_W-1:0]) & pmask;
            probe_n <= probe_n + PCNT_W'(1);
          end else if (rehash) begin
            if (pr_empty) scan_i <= scan_i + (IDX_W+1)'(1);
            else res_error <= E_PROBE;
          end else if (pr_limit) begin
            res_error <= E_PROBE;
          end else begin
            cnt    <= '0;
            scan_i <= '0;
            dst    <= ~bank;
            unique case (mode_r)
              M_INSERT: begin
                if (pr_match) begin
                  res_found <= 1'b1;
                end else begin
                  fill_count <= fill_inc;
                  nlg        <= size_log2 + LG_W'(1);
                  if (grow && size_log2 == LG_W'(MAX_LG)) res_error <= E_FULL;
                end
              end
              M_REMOVE: begin
                if (pr_match) begin
                  res_found  <= 1'b1;
                  fill_count <= fill_dec;
                  nlg        <= size_log2 - LG_W'(1);
                end
              end
              M_LOOKUP: begin
                if (pr_match) begin
                  res_found <= 1'b1;
                  res_value <= rdata.value;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RCLR: cnt <= cnt + IDX_W'(1);
        ST_RRD: begin
          if (scan_i == lg_size(size_log2)) begin
            bank      <= dst;
            size_log2 <= nlg;
          end
        end
        ST_RCHK: begin
          if (rdata.valid) begin
            key_r   <= rdata.key;
            hash_r  <= rdata.hash;
            val_r   <= rdata.value;
            rehash  <= 1'b1;
            p       <= 32'd2;
            idx     <= rdata.hash[IDX_W-1:0] & lg_mask(nlg);
            pmask   <= lg_mask(nlg);
            pbank   <= dst;
            probe_n <= '0;
          end else begin
            scan_i <= scan_i + (IDX_W+1)'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            found     <= res_found;
            value_out <= res_value;
            error     <= res_error;
          end
        end
        default: ;
      endcase
    end
  end

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && error == E_FULL |-> !found)
    else $error("table-full error on an item that found its key");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_out != '0 |-> found)
    else $error("nonzero value without a hit");

  a_fill_fits: assert property (@(posedge clk) disable iff (rst)
    fill_count <= lg_size(size_log2))
    else $error("fill count exceeds table size");

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    size_log2 >= LG_W'(MIN_LG) && size_log2 <= LG_W'(MAX_LG))
    else $error("table size out of range");

  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    state != ST_RRD && state != ST_INIT |=> $stable(bank))
    else $error("bank changed outside a resize commit");

endmodule

@@ tb/tb_quadratic_probe_hash_map.sv @@
module tb_quadratic_probe_hash_map;
  import qphm_pkg::*;

  typedef struct {
    logic        found;
    logic [63:0] value;
    logic [1:0]  error;
  } answer_t;

  // Predictor of the table plus the queue of expected answers.
  class hash_map_scoreboard;
    bit          ok_bank [2][MAX_BUCKETS];
    logic [31:0] key_bank[2][MAX_BUCKETS];
    logic [31:0] hsh_bank[2][MAX_BUCKETS];
    logic [63:0] val_bank[2][MAX_BUCKETS];
    int unsigned lg;
    int unsigned fill;
    int unsigned bank;
    answer_t     pending[$];
    int          fails;

    function void clear();
      foreach (ok_bank[b, i]) ok_bank[b][i] = 0;
      lg = MIN_LG;
      fill = 0;
      bank = 0;
      pending.delete();
      fails = 0;
    endfunction

    // 0 empty, 1 hit, 2 probe limit
    function int walk(int unsigned b, int unsigned l, logic [31:0] k, logic [31:0] h,
                      bit match, output int unsigned where);
      logic [31:0] msk;
      logic [31:0] idx;
      logic [31:0] p;
      logic [63:0] sq;
      msk = (32'd1 << l) - 1;
      idx = h & msk;
      p = 2;
      where = 0;
      for (int i = 0; i < MAX_PROBES; i++) begin
        if (idx >= MAX_BUCKETS || !ok_bank[b][idx]) begin
          where = idx;
          return 0;
        end
        if (match && key_bank[b][idx] == k) begin
          where = idx;
          return 1;
        end
        sq = {32'd0, p} * {32'd0, p} + {32'd0, p};
        p = {1'b0, sq[31:1]};
        idx = (idx + p) & msk;
      end
      return 2;
    endfunction

    function bit rehash(int unsigned nl);
      int unsigned dst;
      int unsigned at;
      dst = bank ^ 1;
      for (int i = 0; i < MAX_BUCKETS; i++) ok_bank[dst][i] = 0;
      for (int i = 0; i < (1 << lg) && i < MAX_BUCKETS; i++) begin
        if (!ok_bank[bank][i]) continue;
        if (walk(dst, nl, key_bank[bank][i], hsh_bank[bank][i], 0, at) != 0
            || at >= MAX_BUCKETS) return 0;
        ok_bank[dst][at] = 1;
        key_bank[dst][at] = key_bank[bank][i];
        hsh_bank[dst][at] = hsh_bank[bank][i];
        val_bank[dst][at] = val_bank[bank][i];
      end
      bank = dst;
      lg = nl;
      return 1;
    endfunction

    function void note_item(logic [1:0] m, logic [31:0] k, logic [31:0] h, logic [63:0] v);
      answer_t a;
      int unsigned at;
      int unsigned sz;
      int r;
      a = '{1'b0, 64'd0, E_OK};
      sz = 1 << lg;
      r = 2;
      if (m == M_INSERT || m == M_REMOVE || m == M_LOOKUP) begin
        r = walk(bank, lg, k, h, 1, at);
        if (at >= MAX_BUCKETS) r = 2;
      end
      if (m == M_INSERT) begin
        if (r == 2) a.error = E_PROBE;
        else begin
          key_bank[bank][at] = k;
          hsh_bank[bank][at] = h;
          val_bank[bank][at] = v;
          if (r == 1) a.found = 1;
          else begin
            ok_bank[bank][at] = 1;
            fill++;
            if (5 * (fill + 2) > 3 * sz) begin
              if (sz >= MAX_BUCKETS) a.error = E_FULL;
              else if (!rehash(lg + 1)) a.error = E_PROBE;
            end
          end
        end
      end else if (m == M_REMOVE) begin
        if (r == 2) a.error = E_PROBE;
        else if (r == 1) begin
          a.found = 1;
          ok_bank[bank][at] = 0;
          if (fill > 0) fill--;
          if (5 * (fill + 2) < sz && sz > MIN_BUCKETS && lg > 0)
            if (!rehash(lg - 1)) a.error = E_PROBE;
        end
      end else if (m == M_LOOKUP) begin
        if (r == 2) a.error = E_PROBE;
        else if (r == 1) begin
          a.found = 1;
          a.value = val_bank[bank][at];
        end
      end
      pending.push_back(a);
    endfunction

    function void check_answer(logic f, logic [63:0] v, logic [1:0] e);
      answer_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result found=%0b value=%h error=%0d", $time, f, v, e);
        fails++;
        return;
      end
      x = pending.pop_front();
      if (f !== x.found) begin
        $display("%0t: found exp %0b got %0b", $time, x.found, f);
        fails++;
      end
      if (v !== x.value) begin
        $display("%0t: value_out exp %h got %h", $time, x.value, v);
        fails++;
      end
      if (e !== x.error) begin
        $display("%0t: error exp %0d got %0d", $time, x.error, e);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [31:0] key;
  logic [31:0] key_hash;
  logic [63:0] value_in;
  logic        out_valid;
  logic        out_stall;
  logic        found;
  logic [63:0] value_out;
  logic [1:0]  error;

  quadratic_probe_hash_map u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .key(key), .key_hash(key_hash), .value_in(value_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .value_out(value_out), .error(error)
  );

  hash_map_scoreboard sb;
  int send_gap_pct;
  int recv_gap_pct;
  bit hold_off;
  bit stim_done;
  int quiet_cycles;
  logic [31:0] live_keys[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_gap_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_answer(found, value_out, error);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // the watchdog leaves room for a full-size rehash with long probe runs
  initial begin
    wait (quiet_cycles >= 300000);
    $display("*** FAILED ***");
    $finish;
  end

  // Keys repeat often: most come from live keys or the range 0 to 300.
  task automatic send_item(logic [1:0] m, logic [31:0] k, logic [31:0] h, logic [63:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    key <= k;
    key_hash <= h;
    value_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(m, k, h, v);
  endtask

  function automatic logic [31:0] hash_of(logic [31:0] k);
    return (k * 32'h9E3779B1) ^ (k >> 7);
  endfunction

  task automatic random_item();
    logic [31:0] k;
    logic [31:0] h;
    int pick;
    pick = $urandom_range(99);
    if (live_keys.size() > 0 && pick < 50) k = live_keys[$urandom_range(live_keys.size() - 1)];
    else if (pick < 90) k = $urandom_range(300);
    else k = $urandom;
    h = ($urandom_range(9) == 0) ? $urandom : hash_of(k);
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_item(M_INSERT, k, h, {$urandom, $urandom});
      live_keys.push_back(k);
    end else if (pick < 70) send_item(M_REMOVE, k, h, {$urandom, $urandom});
    else if (pick < 97) send_item(M_LOOKUP, k, h, {$urandom, $urandom});
    else send_item(2'd3, k, h, {$urandom, $urandom});
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    mode = M_LOOKUP;
    key = '0;
    key_hash = '0;
    value_in = '0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    send_gap_pct = 10;
    recv_gap_pct = 70;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every mode, update, collisions, growth, shrink
    send_item(M_LOOKUP, 32'h0, 32'h0, '0);
    send_item(M_INSERT, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(M_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
    send_item(M_LOOKUP, 32'h0, 32'h0, '0);
    send_item(M_INSERT, 32'h0, 32'h0, 64'h1234_5678_9ABC_DEF0);
    send_item(M_LOOKUP, 32'h0, 32'h0, '0);
    send_item(M_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 1; i <= 6; i++) send_item(M_INSERT, 32'h100 + i, 32'h8, 64'(i));
    send_item(M_LOOKUP, 32'h106, 32'h8, '0);
    for (int i = 1; i <= 6; i++) send_item(M_REMOVE, 32'h100 + i, 32'h8, '0);
    send_item(M_REMOVE, 32'h0, 32'h0, '0);
    send_item(M_REMOVE, 32'h0, 32'h0, '0);
    send_item(M_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);

    for (int i = 0; i < 250; i++) random_item();
    // fill toward the maximum size, with a long receiver hold-off meanwhile
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 250; i++) begin
        send_item(M_INSERT, 32'h1000 + i, hash_of(32'h1000 + i), {$urandom, $urandom});
      end
    join
    send_gap_pct = 70;
    recv_gap_pct = 10;
    for (int i = 0; i < 250; i++) random_item();
    for (int i = 0; i < 250; i++) send_item(M_REMOVE, 32'h1000 + i, hash_of(32'h1000 + i), '0);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    for (int i = 0; i < 220; i++) random_item();
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
